// File: hw/rtl/deadband_telemetry_framer_unit_macros.svh
// Assertion macros for the deadband telemetry framer checker.
`ifndef DEADBAND_TELEMETRY_FRAMER_UNIT_MACROS_SVH
`define DEADBAND_TELEMETRY_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DBTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dbtf assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define DBTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dbtf assertion failed");

// Next-cycle implication that stays live through reset.
`define DBTF_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dbtf assertion failed");

`endif

// File: hw/rtl/dbtf_pkg.sv
// Types, constants and frame byte selection for the deadband telemetry framer.
`timescale 1ns / 1ps
package dbtf_pkg;

    // Frame markers
    localparam logic [7:0] FRAME_SOF0 = 8'hFA;
    localparam logic [7:0] FRAME_SOF1 = 8'hAF;
    localparam logic [7:0] FRAME_EOF  = 8'hED;
    localparam logic [3:0] FRAME_LAST_IDX = 4'hF;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEADBAND = 2'd0;
    localparam logic [1:0] CFG_HOLDOFF  = 2'd1;
    localparam logic [1:0] CFG_TRAILING = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] DEADBAND_RST = 16'd25;
    localparam logic [3:0]  HOLDOFF_RST  = 4'd3;
    localparam logic [7:0]  TRAILING_RST = 8'd5;

    localparam int ENABLE_BIT    = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_DATA_W    = 16;

    typedef struct packed {
        logic signed [15:0] vel_left_back;
        logic signed [15:0] vel_right_back;
        logic signed [15:0] vel_left_front;
        logic signed [15:0] vel_right_front;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [4:0]         switch_bits;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] deadband_threshold;
        logic [3:0]  holdoff_ticks;
        logic [7:0]  trailing_frame_limit;
    } t_cfg;

    // One frame waiting to be serialised, velocities already gated
    typedef struct packed {
        logic [15:0] vel_lb;
        logic [15:0] vel_lf;
        logic [15:0] vel_rb;
        logic [15:0] vel_rf;
        logic [4:0]  switch_bits;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_frame_rec;

    typedef struct packed {
        logic       valid;
        t_frame_rec rec;
    } t_q_rd;

    // Magnitude of a two's complement word, 0..32768
    function automatic logic [16:0] mag17(input logic [15:0] v);
        logic [16:0] res;
        if (v[15]) begin
            res = 17'h10000 - {1'b0, v};
        end else begin
            res = {1'b0, v};
        end
        return res;
    endfunction

    function automatic logic [7:0] frame_byte_at(input t_frame_rec rec,
                                                 input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = FRAME_SOF0;
            4'd1:    b = FRAME_SOF1;
            4'd2:    b = rec.vel_lb[15:8];
            4'd3:    b = rec.vel_lb[7:0];
            4'd4:    b = rec.vel_lf[15:8];
            4'd5:    b = rec.vel_lf[7:0];
            4'd6:    b = rec.vel_rb[15:8];
            4'd7:    b = rec.vel_rb[7:0];
            4'd8:    b = rec.vel_rf[15:8];
            4'd9:    b = rec.vel_rf[7:0];
            4'd10:   b = {3'b000, rec.switch_bits};
            4'd11:   b = rec.pos_x[15:8];
            4'd12:   b = rec.pos_x[7:0];
            4'd13:   b = rec.pos_y[15:8];
            4'd14:   b = rec.pos_y[7:0];
            default: b = FRAME_EOF;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/dbtf_queue.sv
// Small frame queue between the classifier and the serialiser.
`timescale 1ns / 1ps
module dbtf_queue #(
    parameter int DEPTH = dbtf_pkg::QUEUE_DEPTH  // 2 and up
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dbtf_pkg::t_frame_rec  i_rec,
    output logic                  o_full,
    output dbtf_pkg::t_q_rd       o_rd,
    input  logic                  i_pop
);
    import dbtf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_rec       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.rec   = r_mem[r_rd_ptr];

endmodule

// File: hw/rtl/dbtf_front.sv
// Classifier: deadband and hold-off gating, trailing frame decision.
`timescale 1ns / 1ps
module dbtf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dbtf_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  dbtf_pkg::t_in_item    i_item,
    input  logic                  i_q_full,
    output logic                  o_push,
    output dbtf_pkg::t_frame_rec  o_rec
);
    import dbtf_pkg::*;

    logic [4:0]  r_holdoff_count, n_holdoff_count;
    logic [7:0]  r_trailing_count, n_trailing_count;
    logic [16:0] thr;
    logic        still;
    logic        gate_zero;
    logic        send;
    logic        accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign thr     = {1'b0, i_cfg.deadband_threshold};

    assign still = (mag17(i_item.vel_left_back)   < thr) &&
                   (mag17(i_item.vel_right_back)  < thr) &&
                   (mag17(i_item.vel_left_front)  < thr) &&
                   (mag17(i_item.vel_right_front) < thr);

    always_comb begin
        n_holdoff_count  = r_holdoff_count;
        n_trailing_count = r_trailing_count;
        send             = 1'b0;

        priority if (still) begin
            n_holdoff_count = '0;
        end else if (r_holdoff_count < ({1'b0, i_cfg.holdoff_ticks} + 5'd1)) begin
            n_holdoff_count = r_holdoff_count + 5'd1;
        end else begin
            // Saturated: hold
            n_holdoff_count = r_holdoff_count;
        end

        priority if (i_item.switch_bits[ENABLE_BIT]) begin
            send             = 1'b1;
            n_trailing_count = '0;
        end else if (r_trailing_count <= i_cfg.trailing_frame_limit) begin
            send = 1'b1;
            if (r_trailing_count != 8'hFF) begin
                n_trailing_count = r_trailing_count + 8'd1;
            end
        end else begin
            // Past the trailing limit: drop the frame
            send = 1'b0;
        end
    end

    // Standstill or still inside the hold-off window: zero all wheels
    assign gate_zero = still || (n_holdoff_count < {1'b0, i_cfg.holdoff_ticks});

    always_comb begin
        o_rec.vel_lb      = gate_zero ? '0 : i_item.vel_left_back;
        o_rec.vel_lf      = gate_zero ? '0 : i_item.vel_left_front;
        o_rec.vel_rb      = gate_zero ? '0 : i_item.vel_right_back;
        o_rec.vel_rf      = gate_zero ? '0 : i_item.vel_right_front;
        o_rec.switch_bits = i_item.switch_bits;
        o_rec.pos_x       = i_item.pos_x;
        o_rec.pos_y       = i_item.pos_y;
    end

    assign o_push = accept && send;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_count  <= '0;
            r_trailing_count <= '0;
        end else if (accept) begin
            r_holdoff_count  <= n_holdoff_count;
            r_trailing_count <= n_trailing_count;
        end
    end

endmodule

// File: hw/rtl/dbtf_back.sv
// Serialiser: walks the head frame out one byte per transfer.
`timescale 1ns / 1ps
module dbtf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dbtf_pkg::t_q_rd      i_rd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dbtf_pkg::t_out_item  o_item
);
    import dbtf_pkg::*;

    logic       r_valid, n_valid;
    logic [3:0] r_idx, n_idx;
    t_out_item  r_item, n_item;
    logic       load;

    assign load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (load) begin
            if (i_rd.valid) begin
                n_valid           = 1'b1;
                n_item.frame_byte = frame_byte_at(i_rd.rec, r_idx);
                n_item.frame_last = (r_idx == FRAME_LAST_IDX);
                n_idx             = r_idx + 4'd1;
                o_pop             = (r_idx == FRAME_LAST_IDX);
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/deadband_telemetry_framer_unit.sv
// Top level of the deadband telemetry framer: config registers and the three stages.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | i_valid / o_ready  | i_item  (t_in_item, one tick)
//  output  | out       | o_valid / i_ready  | o_item  (t_out_item, one byte)
//  config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  A tick that sends a frame gives the serialiser 16 bytes, one byte per output
//  transfer; the serialiser's byte counter sets that figure.
//  A tick that sends nothing is taken and leaves no trace downstream.
//  The classifier takes a new tick whenever the frame queue has room, so it keeps
//  working while the serialiser is stalled by i_ready.
//  Synchronous active-low reset clears the counters, the queue and o_valid, and
//  reloads the config registers with their defaults; there is no clearing pass.
//
module deadband_telemetry_framer_unit #(
    parameter int QUEUE_DEPTH = dbtf_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  dbtf_pkg::t_in_item              i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output dbtf_pkg::t_out_item             o_item,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [dbtf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dbtf_pkg::*;

    t_cfg       r_cfg;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    t_frame_rec q_wr_rec;
    t_q_rd      q_rd;

    // Config writes land at once; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband_threshold   <= DEADBAND_RST;
            r_cfg.holdoff_ticks        <= HOLDOFF_RST;
            r_cfg.trailing_frame_limit <= TRAILING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEADBAND: r_cfg.deadband_threshold   <= i_cfg_data;
                CFG_HOLDOFF:  r_cfg.holdoff_ticks        <= i_cfg_data[3:0];
                CFG_TRAILING: r_cfg.trailing_frame_limit <= i_cfg_data[7:0];
                default:      r_cfg                      <= r_cfg;
            endcase
        end
    end

    // Front: gate velocities, advance counters, decide whether a frame goes out
    dbtf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_rec    (q_wr_rec)
    );

    // Hold frames so that the two sides stall independently
    dbtf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_wr_rec),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    // Back: emit the head frame byte by byte through a registered output
    dbtf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (q_rd),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

// File: hw/rtl/dbtf_checker.sv
// Port-level checker for the deadband telemetry framer, bound to the top level.
`timescale 1ns / 1ps
`include "deadband_telemetry_framer_unit_macros.svh"
module dbtf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input dbtf_pkg::t_out_item o_item
);
    import dbtf_pkg::*;

    logic stalled;
    logic last_shown;
    logic last_xfer;
    logic eof_byte;
    logic sof_byte;

    assign stalled    = o_valid && !i_ready;
    assign last_shown = o_valid && o_item.frame_last;
    assign last_xfer  = last_shown && i_ready;
    assign eof_byte   = (o_item.frame_byte == FRAME_EOF);
    assign sof_byte   = (o_item.frame_byte == FRAME_SOF0) && !o_item.frame_last;

    // A stalled output byte holds
    `DBTF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, o_valid && $stable(o_item))

    // The closing byte is always the end marker
    `DBTF_ASSERT_IMP(a_last_is_eof, i_clk, i_rst_n, last_shown, eof_byte)

    // A byte shown right after a frame ends opens the next frame
    `DBTF_ASSERT_NEXT(a_sof_follows, i_clk, i_rst_n, last_xfer, !o_valid || sof_byte)

    // Reset drops the output
    `DBTF_ASSERT_ALWAYS_NEXT(a_rst_quiet, i_clk, !i_rst_n, !o_valid)

endmodule

bind deadband_telemetry_framer_unit dbtf_checker u_dbtf_checker (.*);
